>>> rtl/vlrr_pkg.sv
package vlrr_pkg;

	localparam int TableEntriesDefault = 64;
	localparam int VoicesDefault = 16;
	localparam int NotesDefault = 128;

	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 7;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ENTRIES = 2'd0,
		CFG_STYLE = 2'd1,
		CFG_DRUMMER = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_HINT = 2'd1,
		FN_NOTE_ON = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RDCNT,
		ST_EXACT,
		ST_NEAR,
		ST_DECIDE,
		ST_MOD,
		ST_PICK,
		ST_VOICE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [6:0] note;
		logic [6:0] vlo;
		logic [6:0] vhi;
		logic [1:0] style;
		logic [3:0] drummer;
		logic [3:0] artic;
	} entry_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

>>> rtl/vlrr_if.sv
interface vlrr_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [5:0] entry_index;
	logic [6:0] note;
	logic [6:0] velocity;
	logic [6:0] vel_low;
	logic [6:0] vel_high;
	logic [1:0] style_tag;
	logic [3:0] drummer_tag;
	logic [3:0] articulation_tag;
	logic [15:0] active_voices;
	modport source (output valid, func, entry_index, note, velocity, vel_low, vel_high,
		style_tag, drummer_tag, articulation_tag, active_voices, input ready);
	modport sink (input valid, func, entry_index, note, velocity, vel_low, vel_high,
		style_tag, drummer_tag, articulation_tag, active_voices, output ready);
endinterface

interface vlrr_out_if;
	logic valid;
	logic ready;
	logic found;
	logic [5:0] sample_index;
	logic exact_layer;
	logic [6:0] candidate_count;
	logic [3:0] voice_index;
	logic voice_stolen;
	modport source (output valid, found, sample_index, exact_layer, candidate_count,
		voice_index, voice_stolen, input ready);
	modport sink (input valid, found, sample_index, exact_layer, candidate_count,
		voice_index, voice_stolen, output ready);
endinterface

>>> rtl/velocity_layer_round_robin_select_unit.sv
// channel  | dir | handshake     | payload
// in_ch    | in  | valid/ready   | func, entry, note, velocity, tags, voice mask
// out_ch   | out | valid/ready   | found, sample, exact, count, voice, stolen
// cfg      | in  | cfg_we        | cfg_index, cfg_data
// after reset a clearing pass runs over the NOTES counter/hint entries before in_ch is ready
// table and hint writes give no result on out_ch; a note-on always gives one, found or not
// a note-on walks the table for a gather with the hint, again without it if that finds
// nothing, and once more for the pick, with a serial remainder unit before the pick
// one item at a time; in_ch ready is low until a note-on result is taken on out_ch
module velocity_layer_round_robin_select_unit import vlrr_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDefault,
	parameter int VOICES = VoicesDefault,
	parameter int NOTES = NotesDefault
) (
	input logic clk,
	input logic arst_n,
	vlrr_in_if.sink in_ch,
	vlrr_out_if.source out_ch,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int NW = $clog2(NOTES);
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int VM = (VOICES < 16) ? VOICES : 16;

	entry_t tbl_mem [TABLE_ENTRIES];
	logic [3:0] hint_mem [NOTES];
	logic [31:0] rr_mem [NOTES];

	state_t state_q, state_d;
	logic [6:0] entries_q;
	logic [1:0] style_q;
	logic [3:0] drummer_q;

	logic [6:0] note_q, vel_q;
	logic [15:0] active_q;
	logic [3:0] hint_q;
	logic [31:0] rr_q;
	logic use_hint_q;
	logic [CW-1:0] walk_q;
	logic rd_valid_q;
	logic [IW-1:0] rd_idx_q;
	entry_t rd_q;
	logic [CW-1:0] n_exact_q, n_near_q, pick_cnt_q, target_q;
	logic [7:0] best_q;
	logic have_best_q;
	logic [NW-1:0] clr_q;
	logic [IW-1:0] pick_q;
	logic exact_q;
	logic [VW:0] vcnt_q;
	logic [VW-1:0] voice_q;
	logic vfound_q;
	logic div_start;
	logic div_done;
	logic [CW-1:0] div_rem;
	logic out_valid_q;
	logic out_found_q, out_exact_q, out_stolen_q;
	logic [5:0] out_sample_q;
	logic [6:0] out_count_q;
	logic [3:0] out_voice_q;

	logic [CW-1:0] limit;
	logic rd_pass, rd_in_range;
	logic [7:0] centre, gap;

	assign limit = (entries_q > 7'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES) : CW'(entries_q);

	always_comb begin
		rd_pass = (rd_q.note == note_q);
		if ((style_q == 2'd1 || style_q == 2'd2) && rd_q.style != 2'd0 &&
			rd_q.style != style_q)
			rd_pass = 1'b0;
		if (drummer_q != 4'd0 && rd_q.drummer != 4'd0 && rd_q.drummer != drummer_q)
			rd_pass = 1'b0;
		if (use_hint_q && hint_q != 4'd0 && rd_q.artic != 4'd0 && rd_q.artic != hint_q)
			rd_pass = 1'b0;
		rd_in_range = (vel_q >= rd_q.vlo) && (vel_q <= rd_q.vhi);
		centre = ({1'b0, rd_q.vlo} + {1'b0, rd_q.vhi}) >> 1;
		gap = ({1'b0, vel_q} >= centre) ? ({1'b0, vel_q} - centre)
			: (centre - {1'b0, vel_q});
	end

	vlrr_div #(.CntW(CW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(rr_q),
		.divisor(pick_cnt_q),
		.done(div_done),
		.remainder(div_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == NW'(NOTES - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.func == FN_NOTE_ON) state_d = ST_RDCNT;
					else state_d = ST_OUT;
				end
			end
			ST_RDCNT: state_d = ST_EXACT;
			ST_EXACT: if (walk_q == limit && !rd_valid_q) state_d = ST_DECIDE;
			ST_NEAR: if (walk_q == limit && !rd_valid_q) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (n_exact_q != '0 || n_near_q != '0) state_d = ST_MOD;
				else if (use_hint_q) state_d = ST_EXACT;
				else state_d = ST_OUT;
			end
			ST_MOD: if (div_done) state_d = ST_PICK;
			ST_PICK: if (walk_q == limit && !rd_valid_q) state_d = ST_VOICE;
			ST_VOICE: if (vcnt_q == (VW+1)'(VM) || vfound_q) state_d = ST_OUT;
			ST_OUT: if (!out_valid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		div_start = 1'b0;
		if (state_q == ST_DECIDE && (n_exact_q != '0 || n_near_q != '0))
			div_start = 1'b1;
		out_ch.valid = out_valid_q;
		out_ch.found = out_found_q;
		out_ch.sample_index = out_sample_q;
		out_ch.exact_layer = out_exact_q;
		out_ch.candidate_count = out_count_q;
		out_ch.voice_index = out_voice_q;
		out_ch.voice_stolen = out_stolen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			entries_q <= '0;
			style_q <= '0;
			drummer_q <= '0;
			out_valid_q <= 1'b0;
			rd_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + NW'(1);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENTRIES: entries_q <= cfg_data;
					CFG_STYLE: style_q <= cfg_data[1:0];
					CFG_DRUMMER: drummer_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			rd_valid_q <= (state_q == ST_EXACT || state_q == ST_NEAR || state_q == ST_PICK)
				&& walk_q != limit;
			if (state_q == ST_DECIDE && n_exact_q == '0 && n_near_q == '0 && !use_hint_q)
				out_valid_q <= 1'b1;
			if (state_q == ST_VOICE && (vcnt_q == (VW+1)'(VM) || vfound_q))
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			hint_mem[clr_q] <= 4'd0;
			rr_mem[clr_q] <= 32'd0;
		end
		if (state_q == ST_IDLE && in_ch.valid) begin
			note_q <= in_ch.note;
			vel_q <= in_ch.velocity;
			active_q <= in_ch.active_voices;
			if (in_ch.func == FN_WRITE && {26'd0, in_ch.entry_index} < TABLE_ENTRIES)
				tbl_mem[in_ch.entry_index[IW-1:0]] <= '{in_ch.note, in_ch.vel_low,
					in_ch.vel_high, in_ch.style_tag, in_ch.drummer_tag,
					in_ch.articulation_tag};
			if (in_ch.func == FN_HINT)
				hint_mem[in_ch.note[NW-1:0]] <= in_ch.articulation_tag;
			use_hint_q <= 1'b1;
		end
		if (state_q == ST_RDCNT) begin
			hint_q <= hint_mem[note_q[NW-1:0]];
			rr_q <= rr_mem[note_q[NW-1:0]];
			walk_q <= '0;
			n_exact_q <= '0;
			n_near_q <= '0;
			have_best_q <= 1'b0;
			best_q <= '0;
		end
		if ((state_q == ST_EXACT || state_q == ST_NEAR || state_q == ST_PICK)
			&& walk_q != limit) begin
			rd_q <= tbl_mem[walk_q[IW-1:0]];
			rd_idx_q <= walk_q[IW-1:0];
			walk_q <= walk_q + CW'(1);
		end
		if (rd_valid_q && rd_pass) begin
			if (state_q == ST_EXACT || state_q == ST_NEAR) begin
				if (rd_in_range) begin
					n_exact_q <= n_exact_q + CW'(1);
				end else if (!have_best_q || gap < best_q) begin
					have_best_q <= 1'b1;
					best_q <= gap;
					n_near_q <= CW'(1);
				end else if (gap == best_q) begin
					n_near_q <= n_near_q + CW'(1);
				end
			end
			if (state_q == ST_PICK && (rd_in_range == exact_q) &&
				(exact_q || gap == best_q)) begin
				if (target_q == '0) pick_q <= rd_idx_q;
				target_q <= target_q - CW'(1);
			end
		end
		if (state_q == ST_DECIDE) begin
			walk_q <= '0;
			exact_q <= (n_exact_q != '0);
			pick_cnt_q <= (n_exact_q != '0) ? n_exact_q : n_near_q;
			if (n_exact_q == '0 && n_near_q == '0) begin
				if (use_hint_q) begin
					use_hint_q <= 1'b0;
					have_best_q <= 1'b0;
					best_q <= '0;
				end else begin
					out_found_q <= 1'b0;
					out_sample_q <= '0;
					out_exact_q <= 1'b0;
					out_count_q <= '0;
					out_voice_q <= '0;
					out_stolen_q <= 1'b0;
				end
			end
		end
		if (state_q == ST_MOD && div_done) begin
			target_q <= div_rem;
			rr_mem[note_q[NW-1:0]] <= rr_q + 32'd1;
		end
		if (state_q == ST_PICK) begin
			vcnt_q <= '0;
			vfound_q <= 1'b0;
			voice_q <= '0;
		end
		if (state_q == ST_VOICE && !vfound_q && vcnt_q != (VW+1)'(VM)) begin
			if (!active_q[vcnt_q[VW-1:0]]) begin
				vfound_q <= 1'b1;
				voice_q <= vcnt_q[VW-1:0];
			end
			vcnt_q <= vcnt_q + (VW+1)'(1);
		end
		if (state_q == ST_VOICE && (vcnt_q == (VW+1)'(VM) || vfound_q)) begin
			out_found_q <= 1'b1;
			out_sample_q <= 6'(pick_q);
			out_exact_q <= exact_q;
			out_count_q <= 7'(pick_cnt_q);
			out_voice_q <= vfound_q ? 4'(voice_q) : 4'd0;
			out_stolen_q <= !vfound_q;
		end
	end
endmodule

>>> rtl/vlrr_div.sv
module vlrr_div import vlrr_pkg::*; #(
	parameter int CntW = 7
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [CntW-1:0] divisor,
	output logic done,
	output logic [CntW-1:0] remainder
);
	logic [31:0] quo_q;
	logic [CntW:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [CntW:0] trial;

	assign trial = {rem_q[CntW-1:0], quo_q[31]};
	assign remainder = rem_q[CntW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= trial - {1'b0, divisor};
			else
				rem_q <= trial;
		end
	end
endmodule

>>> dv/vlrr_tb_if.sv
interface vlrr_tb_cfg_if;
	logic we;
	logic [1:0] index;
	logic [6:0] data;
endinterface

>>> dv/vlrr_select_checker.sv
module vlrr_select_checker import vlrr_pkg::*; (
	input logic clk,
	input logic arst_n,
	vlrr_in_if.sink in_ch,
	vlrr_out_if.sink out_ch,
	input logic in_ready,
	input logic out_ready,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [6:0] cfg_data,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic found;
		logic [5:0] sample_index;
		logic exact_layer;
		logic [6:0] candidate_count;
		logic [3:0] voice_index;
		logic voice_stolen;
	} pick_t;

	entry_t table_q [64];
	logic [3:0] hint_q [128];
	logic [31:0] rr_count [128];
	logic [6:0] entries_in_use;
	logic [1:0] style_reg;
	logic [3:0] drummer_reg;
	pick_t picks_due [$];

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	function automatic int gather_set(input logic [6:0] note, input logic [6:0] vel,
			input bit use_hint, output bit exact, output int set_q [$]);
		int near_q [$];
		int best;
		int c;
		int d;
		bit have_best;
		int lim;
		logic [3:0] h;
		entry_t e;
		set_q = {};
		have_best = 0;
		best = 0;
		lim = entries_in_use > 64 ? 64 : entries_in_use;
		h = hint_q[note];
		for (int i = 0; i < lim; i++) begin
			e = table_q[i];
			if (e.note != note) continue;
			if ((style_reg == 1 || style_reg == 2) && e.style != 0 && e.style != style_reg)
				continue;
			if (drummer_reg != 0 && e.drummer != 0 && e.drummer != drummer_reg) continue;
			if (use_hint && h != 0 && e.artic != 0 && e.artic != h) continue;
			if (vel >= e.vlo && vel <= e.vhi) begin
				set_q = {set_q, i};
				continue;
			end
			c = (int'(e.vlo) + int'(e.vhi)) / 2;
			d = vel >= c ? vel - c : c - vel;
			if (!have_best || d < best) begin
				have_best = 1;
				best = d;
				near_q = {i};
			end else if (d == best) begin
				near_q = {near_q, i};
			end
		end
		exact = set_q.size() > 0;
		if (!exact) set_q = near_q;
		return set_q.size();
	endfunction

	function automatic void predict_note_on(input logic [6:0] note, input logic [6:0] vel,
			input logic [15:0] active);
		pick_t p;
		bit exact;
		int set_q [$];
		int n;
		p = '0;
		n = gather_set(note, vel, 1, exact, set_q);
		if (n == 0) n = gather_set(note, vel, 0, exact, set_q);
		if (n != 0) begin
			p.found = 1;
			p.sample_index = 6'(set_q[rr_count[note] % n]);
			rr_count[note] = rr_count[note] + 1;
			p.exact_layer = exact;
			p.candidate_count = 7'(n);
			p.voice_stolen = 1;
			for (int v = 0; v < 16; v++) begin
				if (!active[v]) begin
					p.voice_index = 4'(v);
					p.voice_stolen = 0;
					break;
				end
			end
		end
		picks_due = {picks_due, p};
	endfunction

	assign pending = picks_due.size();

	always @(posedge clk or negedge arst_n) begin
		pick_t w;
		pick_t g;
		if (!arst_n) begin
			fail_count = 0;
			picks_due = {};
			for (int i = 0; i < 64; i++) table_q[i] = '0;
			for (int i = 0; i < 128; i++) begin
				hint_q[i] = '0;
				rr_count[i] = '0;
			end
			entries_in_use = 0;
			style_reg = 0;
			drummer_reg = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
				CFG_ENTRIES: entries_in_use = cfg_data;
				CFG_STYLE: style_reg = cfg_data[1:0];
				CFG_DRUMMER: drummer_reg = cfg_data[3:0];
				default: ;
				endcase
			end
			if (out_ch.valid && out_ready) begin
				g = {out_ch.found, out_ch.sample_index, out_ch.exact_layer,
					out_ch.candidate_count, out_ch.voice_index, out_ch.voice_stolen};
				if (picks_due.size() == 0) begin
					report("unexpected item", 1, 0);
				end else begin
					w = picks_due.pop_front();
					if (g.found !== w.found) report("found", g.found, w.found);
					if (g.sample_index !== w.sample_index)
						report("sample_index", g.sample_index, w.sample_index);
					if (g.exact_layer !== w.exact_layer)
						report("exact_layer", g.exact_layer, w.exact_layer);
					if (g.candidate_count !== w.candidate_count)
						report("candidate_count", g.candidate_count, w.candidate_count);
					if (g.voice_index !== w.voice_index)
						report("voice_index", g.voice_index, w.voice_index);
					if (g.voice_stolen !== w.voice_stolen)
						report("voice_stolen", g.voice_stolen, w.voice_stolen);
				end
			end
			if (in_ch.valid && in_ready) begin
				case (in_ch.func)
				FN_WRITE: table_q[in_ch.entry_index] = '{note: in_ch.note,
					vlo: in_ch.vel_low, vhi: in_ch.vel_high, style: in_ch.style_tag,
					drummer: in_ch.drummer_tag, artic: in_ch.articulation_tag};
				FN_HINT: hint_q[in_ch.note] = in_ch.articulation_tag;
				FN_NOTE_ON: predict_note_on(in_ch.note, in_ch.velocity, in_ch.active_voices);
				default: ;
				endcase
			end
		end
	end
endmodule

>>> dv/tb_velocity_layer_round_robin_select_unit.sv
module tb_velocity_layer_round_robin_select_unit import vlrr_pkg::*;;
	logic clk;
	logic arst_n;
	vlrr_in_if in_ch ();
	vlrr_out_if out_ch ();
	vlrr_tb_cfg_if cfg ();
	int fail_count;
	int pending;
	int send_idle;
	int recv_idle;
	bit hold_off;
	int quiet_cycles;
	bit done_stim;

	velocity_layer_round_robin_select_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
	);

	vlrr_select_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
		.in_ready(in_ch.ready), .out_ready(out_ch.ready),
		.cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver side: random stall, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
		end
	end

	// no item accepted for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| done_stim)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("tb_velocity_layer_round_robin_select_unit: FAIL");
			$finish;
		end
	end

	task automatic write_cfg(input cfg_idx_t idx, input int value);
		@(posedge clk);
		cfg.we <= 1'b1;
		cfg.index <= idx;
		cfg.data <= 7'(value);
		@(posedge clk);
		cfg.we <= 1'b0;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic send_item(input func_t fn, input int idx, input int note, input int vel,
			input int vlo, input int vhi, input int sty, input int drm, input int art,
			input int act);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= fn;
		in_ch.entry_index <= 6'(idx);
		in_ch.note <= 7'(note);
		in_ch.velocity <= 7'(vel);
		in_ch.vel_low <= 7'(vlo);
		in_ch.vel_high <= 7'(vhi);
		in_ch.style_tag <= 2'(sty);
		in_ch.drummer_tag <= 4'(drm);
		in_ch.articulation_tag <= 4'(art);
		in_ch.active_voices <= 16'(act);
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// notes crowd onto a few values so filters and round robin get exercised
	function automatic int pick_note();
		return $urandom_range(3) == 0 ? $urandom_range(127) : 36 + $urandom_range(3);
	endfunction

	task automatic random_item();
		int r;
		int lo;
		int hi;
		int act;
		r = $urandom_range(99);
		lo = $urandom_range(127);
		hi = $urandom_range(2) == 0 ? $urandom_range(127) : lo + $urandom_range(127 - lo);
		act = $urandom_range(3) == 0 ? 16'hffff : $urandom_range(16'hffff);
		if (r < 25)
			send_item(FN_WRITE, $urandom_range(63), pick_note(), 0, lo, hi,
				$urandom_range(3), $urandom_range(15), $urandom_range(15), act);
		else if (r < 33)
			send_item(FN_HINT, $urandom_range(63), pick_note(), $urandom_range(127), lo, hi,
				$urandom_range(3), $urandom_range(15), $urandom_range(15), act);
		else if (r < 35)
			send_item(func_t'(2'd3), $urandom_range(63), pick_note(), $urandom_range(127),
				lo, hi, 3, 15, 15, act);
		else
			send_item(FN_NOTE_ON, $urandom_range(63), pick_note(), $urandom_range(1, 127),
				lo, hi, $urandom_range(3), $urandom_range(15), $urandom_range(15), act);
	endtask

	initial begin
		int lim;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = FN_WRITE;
		in_ch.entry_index = '0;
		in_ch.note = '0;
		in_ch.velocity = '0;
		in_ch.vel_low = '0;
		in_ch.vel_high = '0;
		in_ch.style_tag = '0;
		in_ch.drummer_tag = '0;
		in_ch.articulation_tag = '0;
		in_ch.active_voices = '0;
		cfg.we = 1'b0;
		cfg.index = CFG_ENTRIES;
		cfg.data = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_off = 0;
		done_stim = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// fill every entry so no unwritten entry is ever read
		for (int i = 0; i < 64; i++)
			send_item(FN_WRITE, i, 36 + (i % 4), 0, (i * 7) % 100, (i * 7) % 100 + 20,
				i % 4, i % 3 == 0 ? 0 : i % 16, i % 14, 16'h0);
		drain();
		write_cfg(CFG_ENTRIES, 64);

		// directed: extremes, empty result, hints, stolen voice, unknown func
		send_item(FN_NOTE_ON, 0, 127, 127, 0, 0, 0, 0, 0, 16'hffff);
		send_item(FN_NOTE_ON, 0, 36, 1, 0, 0, 0, 0, 0, 16'h0000);
		send_item(FN_NOTE_ON, 0, 36, 127, 0, 0, 0, 0, 0, 16'h7fff);
		send_item(FN_WRITE, 63, 127, 0, 127, 127, 3, 15, 13, 16'hffff);
		send_item(FN_WRITE, 62, 127, 0, 0, 0, 0, 0, 0, 16'h0);
		send_item(FN_NOTE_ON, 0, 127, 127, 0, 0, 0, 0, 0, 16'hfffe);
		send_item(FN_NOTE_ON, 0, 127, 64, 0, 0, 0, 0, 0, 16'h8000);
		send_item(FN_HINT, 0, 37, 0, 0, 0, 0, 0, 5, 16'h0);
		send_item(FN_NOTE_ON, 0, 37, 50, 0, 0, 0, 0, 0, 16'h0);
		send_item(FN_HINT, 0, 37, 0, 0, 0, 0, 0, 13, 16'h0);
		send_item(FN_NOTE_ON, 0, 37, 50, 0, 0, 0, 0, 0, 16'h0);
		send_item(FN_HINT, 0, 37, 0, 0, 0, 0, 0, 0, 16'h0);
		send_item(func_t'(2'd3), 63, 127, 127, 127, 127, 3, 15, 15, 16'hffff);
		for (int k = 0; k < 5; k++) send_item(FN_NOTE_ON, 0, 38, 60, 0, 0, 0, 0, 0, 16'h0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
			0: begin send_idle = 0; recv_idle = 0; end
			1: begin send_idle = 83; recv_idle = 0; end
			2: begin send_idle = 0; recv_idle = 83; end
			default: begin send_idle = 20; recv_idle = 20; end
			endcase
			write_cfg(CFG_STYLE, ph == 7 ? 3 : ph % 3);
			write_cfg(CFG_DRUMMER, ph == 0 ? 0 : (ph == 1 ? 15 : $urandom_range(15)));
			lim = ph == 3 ? 0 : (ph == 5 ? 1 : 64 - $urandom_range(ph * 3));
			write_cfg(CFG_ENTRIES, ph == 6 ? 127 : lim);
			if (ph == 2) begin
				fork
					begin
						hold_off = 1;
						repeat (2000) @(posedge clk);
						hold_off = 0;
					end
					for (int k = 0; k < 4; k++)
						send_item(FN_NOTE_ON, 0, 36, $urandom_range(1, 127), 0, 0, 0, 0, 0, 0);
				join
			end
			for (int k = 0; k < 110; k++) random_item();
			drain();
		end
		done_stim = 1;

		if (fail_count == 0)
			$display("tb_velocity_layer_round_robin_select_unit: PASS");
		else
			$display("tb_velocity_layer_round_robin_select_unit: FAIL");
		$finish;
	end
endmodule
